// File: hdl/ddt_pkg.sv
// ----------------------------------------------------------------------------
// Deferred decrement table package
// Shared constants, codes, state type and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package ddt_pkg;

  localparam int DEPTH_DEFAULT       = 64;
  localparam int KEY_WIDTH_DEFAULT   = 64;
  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam logic [15:0] BATCH_DEFAULT = 16'd32;

  localparam logic [1:0] ACT_DEFER = 2'd0;
  localparam logic [1:0] ACT_PROC  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  localparam logic [1:0] ST_COUNTED = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRD,
    S_DCMP,
    S_DNEW,
    S_WBEG,
    S_WRD,
    S_WUPD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       set_status;
    logic [1:0] status;
    logic       scan_rd;
    logic       scan_cmp;
    logic       defer_new;
    logic       pass_begin;
    logic       step_rd;
    logic       step_upd;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_act;
    logic       in_key_zero;
    logic [1:0] act;
    logic       hit;
    logic       scan_last;
    logic       found;
    logic       pass_end;
    logic       more_pass;
  } stat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  pending;
    logic        due;
    logic [22:0] done;
    logic [6:0]  gone;
    logic [31:0] drop;
    logic [31:0] add;
  } res_t;

endpackage

// File: hdl/ddt_ctrl.sv
// ----------------------------------------------------------------------------
// Deferred decrement table controller
// Sequences lookups, insertions and walks over the entry order.
// ----------------------------------------------------------------------------
module ddt_ctrl
  import ddt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  logic  out_free,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && s_tready) begin
          cmd.accept = 1'b1;
          priority if (stat.in_act == ACT_DEFER && !stat.in_key_zero) begin
            state_next = S_DRD;
          end else if (stat.in_act == ACT_PROC || stat.in_act == ACT_FLUSH) begin
            state_next = S_WBEG;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_IGNORED;
            state_next     = S_FIN;
          end
        end
      end
      S_DRD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_DCMP;
      end
      S_DCMP: begin
        cmd.scan_cmp = 1'b1;
        priority if (stat.hit) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_COUNTED;
          state_next     = S_FIN;
        end else if (stat.scan_last) begin
          state_next = S_DNEW;
        end else begin
          state_next = S_DRD;
        end
      end
      S_DNEW: begin
        cmd.defer_new  = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = stat.found ? ST_NEW : ST_DROPPED;
        state_next     = S_FIN;
      end
      S_WBEG: begin
        cmd.pass_begin = 1'b1;
        state_next     = S_WRD;
      end
      S_WRD: begin
        priority if (!stat.pass_end) begin
          cmd.step_rd = 1'b1;
          state_next  = S_WUPD;
        end else if (stat.act == ACT_FLUSH && stat.more_pass) begin
          state_next = S_WBEG;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_COUNTED;
          state_next     = S_FIN;
        end
      end
      S_WUPD: begin
        cmd.step_upd = 1'b1;
        state_next   = S_WRD;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/ddt_dpath.sv
// ----------------------------------------------------------------------------
// Deferred decrement table datapath
// Entry memories, valid bits, order links, counters and the batch register.
// ----------------------------------------------------------------------------
module ddt_dpath
  import ddt_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [79:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output res_t        res
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W = $clog2(DEPTH + 1);
  localparam int PEND_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] END_PTR = PTR_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  logic [KEY_WIDTH-1:0]   mem_key [DEPTH];
  logic [COUNT_WIDTH-1:0] mem_cnt [DEPTH];
  logic [PTR_W-1:0]       mem_nxt [DEPTH];

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [PTR_W-1:0]       rd_nxt;

  logic [DEPTH-1:0]  valid;
  logic [PTR_W-1:0]  head;
  logic [PEND_W-1:0] pending;
  logic [31:0]       drop;
  logic [31:0]       add;
  logic [15:0]       batch;

  logic [1:0]           act;
  logic [KEY_WIDTH-1:0] key;
  logic [15:0]          step_cap;
  logic [1:0]           status;
  logic [IDX_W-1:0]     scan;
  logic [IDX_W-1:0]     slot;
  logic                 found;
  logic [PTR_W-1:0]     cur;
  logic [PTR_W-1:0]     prev;
  logic [15:0]          steps;
  logic [22:0]          done;
  logic [6:0]           gone;

  logic [15:0]            eff_batch;
  logic [15:0]            limit;
  logic                   hit;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [IDX_W-1:0]       cur_idx;
  logic [IDX_W-1:0]       prev_idx;
  logic [IDX_W-1:0]       rd_addr;

  assign eff_batch = (batch == 16'd0) ? BATCH_DEFAULT : batch;
  assign limit     = (act == ACT_FLUSH) ? eff_batch : step_cap;
  assign hit       = valid[scan] && (rd_key == key);
  assign cnt_dec   = rd_cnt - COUNT_ONE;
  assign cnt_inc   = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_ONE;
  assign cur_idx   = cur[IDX_W-1:0];
  assign prev_idx  = prev[IDX_W-1:0];
  assign rd_addr   = cmd.scan_rd ? scan : cur_idx;

  always_comb begin
    stat.in_act      = s_tuser;
    stat.in_key_zero = (s_tdata[KEY_WIDTH-1:0] == '0);
    stat.act         = act;
    stat.hit         = hit;
    stat.scan_last   = (scan == LAST_IDX);
    stat.found       = found;
    stat.pass_end    = (cur == END_PTR) || (steps == limit);
    stat.more_pass   = (head != END_PTR);
  end

  always_comb begin
    res.status  = status;
    res.pending = 7'(pending);
    res.due     = (32'(pending) >= 32'(eff_batch));
    res.done    = done;
    res.gone    = gone;
    res.drop    = drop;
    res.add     = add;
  end

  // Entry memories: one read port with registered data, one write per cycle.
  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.step_rd) begin
      rd_key <= mem_key[rd_addr];
      rd_cnt <= mem_cnt[rd_addr];
      rd_nxt <= mem_nxt[rd_addr];
    end
    if (cmd.defer_new && found) begin
      mem_key[slot] <= key;
      mem_cnt[slot] <= COUNT_ONE;
      mem_nxt[slot] <= head;
    end else if (cmd.scan_cmp && hit) begin
      mem_cnt[scan] <= cnt_inc;
    end else if (cmd.step_upd) begin
      mem_cnt[cur_idx] <= cnt_dec;
      if (cnt_dec == '0 && prev != END_PTR) begin
        mem_nxt[prev_idx] <= rd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      head    <= END_PTR;
      pending <= '0;
      drop    <= '0;
      add     <= '0;
      batch   <= BATCH_DEFAULT;
    end else begin
      if (cfg_valid) begin
        batch <= cfg_data;
      end
      if (cmd.defer_new) begin
        if (found) begin
          valid[slot] <= 1'b1;
          head        <= PTR_W'(slot);
          pending     <= pending + PEND_W'(1);
          add         <= add + 32'd1;
        end else begin
          drop <= drop + 32'd1;
        end
      end
      if (cmd.step_upd && cnt_dec == '0) begin
        // The visited entry is unlinked from the order.
        if (prev == END_PTR) begin
          head <= rd_nxt;
        end
        valid[cur_idx] <= 1'b0;
        pending        <= pending - PEND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act      <= s_tuser;
      key      <= s_tdata[KEY_WIDTH-1:0];
      step_cap <= s_tdata[79:64];
      done     <= '0;
      gone     <= '0;
      scan     <= '0;
      found    <= 1'b0;
    end
    if (cmd.set_status) begin
      status <= cmd.status;
    end
    if (cmd.scan_cmp && !hit) begin
      if (!valid[scan] && !found) begin
        slot  <= scan;
        found <= 1'b1;
      end
      scan <= scan + IDX_W'(1);
    end
    if (cmd.pass_begin) begin
      cur   <= head;
      prev  <= END_PTR;
      steps <= '0;
    end
    if (cmd.step_upd) begin
      steps <= steps + 16'd1;
      done  <= done + 23'd1;
      cur   <= rd_nxt;
      if (cnt_dec == '0) begin
        gone <= gone + 7'd1;
      end else begin
        prev <= cur;
      end
    end
  end

endmodule

// File: hdl/deferred_decrement_table_top.sv
// Steps from input to output transfer: a defer reads and compares each slot in turn
// until a hit or the last slot, then inserts; an ignored item goes straight to the output;
// a process walks one pass with a read and an update per step; a flush repeats passes.
// One item is in work at a time; the lookup scan and the walk share the single read port.
// Reset is synchronous: valid bits clear at once, the order is empty, counters
// are zero and the batch threshold is 32; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Deferred decrement table
// Pending decrement table with lookup, insertion, batch walk and flush.
// ----------------------------------------------------------------------------
module deferred_decrement_table_top
  import ddt_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // key[63:0], step limit[79:64]
  input  logic [1:0]   s_tuser,   // action[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // pending entries, due, processed, removed,
                                  // dropped_total, added_total, zero pad
  output logic [1:0]   m_tuser,   // status[1:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data   // batch threshold
);

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  out_free;

  assign cfg_ready = !rst;
  assign out_free  = !m_tvalid || m_tready;

  ddt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddt_dpath #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res)
  );

  // Output register: holds a finished result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= res.status;
      m_tdata <= {2'b00, res.add, res.drop, res.gone, res.done, res.due, res.pending};
    end
  end

endmodule
